FILE: hw/rtl/cdg_pkg.sv
// shared constants, register codes and control types of the gradient unit
`timescale 1ns / 1ps
package cdg_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_PIXEL_BITS = 8;

  localparam int CFG_W      = 11;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam int OUT_POS_W = 10;
  localparam int DIFF_W    = 9;
  localparam int DIFF_LIM  = 255;

  localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 11'd480;

  // register index, taken from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // result kinds per pixel, in emission order
  localparam logic [1:0] RES_UP   = 2'd0;
  localparam logic [1:0] RES_LEFT = 2'd1;
  localparam logic [1:0] RES_HERE = 2'd2;
  localparam int         RES_N    = 3;

  typedef struct packed {
    logic res_up;
    logic res_left;
    logic res_here;
    logic first_col;
    logic last_col;
    logic row_one;
    logic col_one;
  } cdg_ctrl_t;

endpackage

FILE: hw/rtl/cdg_if.sv
// pixel and result stream interfaces
`timescale 1ns / 1ps
interface cdg_pix_if #(
  parameter int PIXEL_BITS = cdg_pkg::DEF_PIXEL_BITS
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface cdg_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [cdg_pkg::DIFF_W-1:0]   dx_twice;
  logic signed [cdg_pkg::DIFF_W-1:0]   dy_twice;
  logic        [cdg_pkg::OUT_POS_W-1:0] out_row;
  logic        [cdg_pkg::OUT_POS_W-1:0] out_col;
  logic                                run_end;
  logic                                frame_end;

  modport source (output valid, output dx_twice, output dy_twice, output out_row,
                  output out_col, output run_end, output frame_end, input ready);
  modport sink   (input valid, input dx_twice, input dy_twice, input out_row,
                  input out_col, input run_end, input frame_end, output ready);
endinterface

FILE: hw/rtl/cdg_cfg_regs.sv
// apb geometry registers with clamping and frame restart
`timescale 1ns / 1ps
module cdg_cfg_regs #(
  parameter int MAX_WIDTH  = cdg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cdg_pkg::DEF_MAX_HEIGHT,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cdg_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [cdg_pkg::APB_DATA_W-1:0] pwdata,
  output logic [cdg_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [CW-1:0]                  w_last,
  output logic [RW-1:0]                  h_last,
  output logic                           restart
);

  localparam int XW = (cdg_pkg::CFG_W > CW + 1) ? cdg_pkg::CFG_W : CW + 1;
  localparam int YW = (cdg_pkg::CFG_W > RW + 1) ? cdg_pkg::CFG_W : RW + 1;

  logic [cdg_pkg::CFG_W-1:0] frame_width_r;
  logic [cdg_pkg::CFG_W-1:0] frame_height_r;
  logic [cdg_pkg::CFG_W-1:0] frame_width_nxt;
  logic [cdg_pkg::CFG_W-1:0] frame_height_nxt;
  logic [XW-1:0]             wv;
  logic [YW-1:0]             hv;
  logic                      wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign restart = wr_en;

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (wr_en) begin
      unique case (paddr[2])
        cdg_pkg::REG_FRAME_WIDTH:  frame_width_nxt  = pwdata[cdg_pkg::CFG_W-1:0];
        cdg_pkg::REG_FRAME_HEIGHT: frame_height_nxt = pwdata[cdg_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= cdg_pkg::RESET_FRAME_WIDTH;
      frame_height_r <= cdg_pkg::RESET_FRAME_HEIGHT;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      cdg_pkg::REG_FRAME_WIDTH:  prdata = cdg_pkg::APB_DATA_W'(frame_width_r);
      cdg_pkg::REG_FRAME_HEIGHT: prdata = cdg_pkg::APB_DATA_W'(frame_height_r);
      default:                   prdata = '0;
    endcase
  end

  // clamp to 2..max, expressed as last index
  always_comb begin
    wv = XW'(frame_width_r);
    hv = YW'(frame_height_r);
    if (wv < XW'(2)) begin
      w_last = CW'(1);
    end else if (wv > XW'(MAX_WIDTH)) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(wv - XW'(1));
    end
    if (hv < YW'(2)) begin
      h_last = RW'(1);
    end else if (hv > YW'(MAX_HEIGHT)) begin
      h_last = RW'(MAX_HEIGHT - 1);
    end else begin
      h_last = RW'(hv - YW'(1));
    end
  end

endmodule

FILE: hw/rtl/cdg_line_buf.sv
// raster counters, two line memories and the pixel window stage
`timescale 1ns / 1ps
module cdg_line_buf #(
  parameter int MAX_WIDTH  = cdg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cdg_pkg::DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = cdg_pkg::DEF_PIXEL_BITS,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  cdg_pix_if.sink                in_pix,
  input  logic [CW-1:0]          w_last,
  input  logic [RW-1:0]          h_last,
  input  logic                   restart,
  input  logic                   retire,
  output logic                   s_valid,
  output cdg_pkg::cdg_ctrl_t     s_ctrl,
  output logic [PIXEL_BITS-1:0]  s_pix,
  output logic [PIXEL_BITS-1:0]  s_mid_c,
  output logic [PIXEL_BITS-1:0]  s_mid_r,
  output logic [PIXEL_BITS-1:0]  s_up,
  output logic [PIXEL_BITS-1:0]  s_mid_l,
  output logic [PIXEL_BITS-1:0]  s_last,
  output logic [PIXEL_BITS-1:0]  s_second,
  output logic [RW-1:0]          s_row,
  output logic [CW-1:0]          s_col
);

  logic [PIXEL_BITS-1:0] prev_mem  [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] older_mem [MAX_WIDTH];

  logic [CW-1:0]         col_r, col_nxt, col_ahead;
  logic [RW-1:0]         row_r, row_nxt;
  logic                  s_valid_r, s_valid_nxt;
  logic [PIXEL_BITS-1:0] last_pix_r, second_pix_r, mid_l_r;
  logic [PIXEL_BITS-1:0] s_pix_r, s_mid_c_r, s_mid_r_r, s_up_r, s_last_r, s_second_r;
  logic [RW-1:0]         s_row_r;
  logic [CW-1:0]         s_col_r;
  cdg_pkg::cdg_ctrl_t    s_ctrl_r, ctrl_new;
  logic                  accept, last_col, last_row;

  assign in_pix.ready = !s_valid_r || retire;
  assign accept       = in_pix.valid && in_pix.ready;

  assign last_col  = (col_r == w_last);
  assign last_row  = (row_r == h_last);
  assign col_ahead = (col_r == CW'(MAX_WIDTH - 1)) ? '0 : col_r + CW'(1);

  always_comb begin
    ctrl_new.res_up    = (row_r != '0);
    ctrl_new.res_left  = last_row && (col_r != '0);
    ctrl_new.res_here  = last_row && last_col;
    ctrl_new.first_col = (col_r == '0);
    ctrl_new.last_col  = last_col;
    ctrl_new.row_one   = (row_r == RW'(1));
    ctrl_new.col_one   = (col_r == CW'(1));
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    priority if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end else begin
      col_nxt = col_r;
      row_nxt = row_r;
    end
  end

  always_comb begin
    s_valid_nxt = s_valid_r;
    priority if (accept) begin
      s_valid_nxt = 1'b1;
    end else if (retire) begin
      s_valid_nxt = 1'b0;
    end else begin
      s_valid_nxt = s_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      s_valid_r    <= 1'b0;
      last_pix_r   <= '0;
      second_pix_r <= '0;
      mid_l_r      <= '0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      s_valid_r <= s_valid_nxt;
      if (accept) begin
        last_pix_r   <= in_pix.pixel;
        second_pix_r <= last_pix_r;
      end
      if (retire) begin
        mid_l_r <= s_mid_c_r;
      end
    end
  end

  // window stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s_pix_r    <= in_pix.pixel;
      s_last_r   <= last_pix_r;
      s_second_r <= second_pix_r;
      s_row_r    <= row_r;
      s_col_r    <= col_r;
      s_ctrl_r   <= ctrl_new;
    end
  end

  // previous row: read center and right neighbor, write incoming pixel
  always_ff @(posedge clk) begin
    if (accept) begin
      s_mid_c_r      <= prev_mem[col_r];
      s_mid_r_r      <= prev_mem[col_ahead];
      prev_mem[col_r] <= in_pix.pixel;
    end
  end

  // older row: read on transfer, written back when the stage retires
  always_ff @(posedge clk) begin
    if (accept) begin
      s_up_r <= older_mem[col_r];
    end
    if (retire) begin
      older_mem[s_col_r] <= s_mid_c_r;
    end
  end

  assign s_valid  = s_valid_r;
  assign s_ctrl   = s_ctrl_r;
  assign s_pix    = s_pix_r;
  assign s_mid_c  = s_mid_c_r;
  assign s_mid_r  = s_mid_r_r;
  assign s_up     = s_up_r;
  assign s_mid_l  = mid_l_r;
  assign s_last   = s_last_r;
  assign s_second = s_second_r;
  assign s_row    = s_row_r;
  assign s_col    = s_col_r;

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= w_last)
    else $error("column counter beyond row end");

  a_stage_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s_valid_r)
    else $error("window stage not loaded after transfer");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s_valid_r |-> in_pix.ready)
    else $error("input not ready with empty window stage");

endmodule

FILE: hw/rtl/cdg_result_seq.sv
// difference datapath, per-pixel result sequencer and output register
`timescale 1ns / 1ps
module cdg_result_seq #(
  parameter int MAX_WIDTH  = cdg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cdg_pkg::DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = cdg_pkg::DEF_PIXEL_BITS,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   s_valid,
  input  cdg_pkg::cdg_ctrl_t     s_ctrl,
  input  logic [PIXEL_BITS-1:0]  s_pix,
  input  logic [PIXEL_BITS-1:0]  s_mid_c,
  input  logic [PIXEL_BITS-1:0]  s_mid_r,
  input  logic [PIXEL_BITS-1:0]  s_up,
  input  logic [PIXEL_BITS-1:0]  s_mid_l,
  input  logic [PIXEL_BITS-1:0]  s_last,
  input  logic [PIXEL_BITS-1:0]  s_second,
  input  logic [RW-1:0]          s_row,
  input  logic [CW-1:0]          s_col,
  output logic                   retire,
  cdg_res_if.source              out_res
);

  localparam int DW = PIXEL_BITS + 2;
  localparam logic signed [DW-1:0] LIM_HI = DW'(cdg_pkg::DIFF_LIM);
  localparam logic signed [DW-1:0] LIM_LO = -LIM_HI;

  function automatic logic signed [cdg_pkg::DIFF_W-1:0] sat_diff(
    input logic [PIXEL_BITS-1:0] a,
    input logic [PIXEL_BITS-1:0] b
  );
    logic signed [DW-1:0] d;
    d = $signed({2'b00, a}) - $signed({2'b00, b});
    if (d > LIM_HI) begin
      d = LIM_HI;
    end else if (d < LIM_LO) begin
      d = LIM_LO;
    end
    return cdg_pkg::DIFF_W'(d);
  endfunction

  logic [cdg_pkg::RES_N-1:0] done_r, done_nxt, has, pend, sel_oh, rest;
  logic [1:0]                sel_idx;
  logic                      out_space, push;
  logic [PIXEL_BITS-1:0]     dx_a, dx_b, dy_a, dy_b;
  logic [RW-1:0]             row_sel;
  logic [CW-1:0]             col_sel;

  logic                                out_valid_r;
  logic signed [cdg_pkg::DIFF_W-1:0]   dx_r, dy_r;
  logic        [cdg_pkg::OUT_POS_W-1:0] row_r, col_r;
  logic                                run_end_r, frame_end_r;

  always_comb begin
    has                    = '0;
    has[cdg_pkg::RES_UP]   = s_ctrl.res_up;
    has[cdg_pkg::RES_LEFT] = s_ctrl.res_left;
    has[cdg_pkg::RES_HERE] = s_ctrl.res_here;
    pend                   = s_valid ? (has & ~done_r) : '0;
    priority if (pend[cdg_pkg::RES_UP]) begin
      sel_idx = cdg_pkg::RES_UP;
    end else if (pend[cdg_pkg::RES_LEFT]) begin
      sel_idx = cdg_pkg::RES_LEFT;
    end else begin
      sel_idx = cdg_pkg::RES_HERE;
    end
    sel_oh = cdg_pkg::RES_N'(1) << sel_idx;
    rest   = pend & ~sel_oh;
  end

  assign out_space = !out_valid_r || out_res.ready;
  assign push      = (pend != '0) && out_space;
  assign retire    = s_valid && ((pend == '0) || (push && (rest == '0)));

  always_comb begin
    done_nxt = done_r;
    priority if (retire) begin
      done_nxt = '0;
    end else if (push) begin
      done_nxt = done_r | sel_oh;
    end else begin
      done_nxt = done_r;
    end
  end

  // operand selection for the chosen result
  always_comb begin
    unique case (sel_idx)
      cdg_pkg::RES_UP: begin
        priority if (s_ctrl.first_col) begin
          dx_a = s_mid_r;
          dx_b = s_mid_c;
        end else if (s_ctrl.last_col) begin
          dx_a = s_mid_c;
          dx_b = s_mid_l;
        end else begin
          dx_a = s_mid_r;
          dx_b = s_mid_l;
        end
        dy_a    = s_pix;
        dy_b    = s_ctrl.row_one ? s_mid_c : s_up;
        row_sel = s_row - RW'(1);
        col_sel = s_col;
      end
      cdg_pkg::RES_LEFT: begin
        dx_a    = s_pix;
        dx_b    = s_ctrl.col_one ? s_last : s_second;
        dy_a    = s_last;
        dy_b    = s_mid_l;
        row_sel = s_row;
        col_sel = s_col - CW'(1);
      end
      default: begin
        dx_a    = s_pix;
        dx_b    = s_last;
        dy_a    = s_pix;
        dy_b    = s_mid_c;
        row_sel = s_row;
        col_sel = s_col;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
      priority if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end else begin
        out_valid_r <= out_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      dx_r        <= sat_diff(dx_a, dx_b);
      dy_r        <= sat_diff(dy_a, dy_b);
      row_r       <= cdg_pkg::OUT_POS_W'(row_sel);
      col_r       <= cdg_pkg::OUT_POS_W'(col_sel);
      run_end_r   <= (rest == '0);
      frame_end_r <= (sel_idx == cdg_pkg::RES_HERE);
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.dx_twice  = dx_r;
  assign out_res.dy_twice  = dy_r;
  assign out_res.out_row   = row_r;
  assign out_res.out_col   = col_r;
  assign out_res.run_end   = run_end_r;
  assign out_res.frame_end = frame_end_r;

  a_frame_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.frame_end |-> out_res.run_end)
    else $error("frame end without run end");

  a_retire_clears: assert property (@(posedge clk) disable iff (!rst_n)
    retire |=> (done_r == '0))
    else $error("emitted mask not cleared after retire");

  a_done_subset: assert property (@(posedge clk) disable iff (!rst_n)
    s_valid |-> ((done_r & ~has) == '0))
    else $error("result emitted that the pixel does not produce");

endmodule

FILE: hw/rtl/image_central_difference_gradient_unit.sv
// top level of the streaming central-difference gradient unit
//
// channel   dir  handshake             contents
// in_pix    in   valid/ready           pixel
// out_res   out  valid/ready           dx_twice dy_twice out_row out_col run_end frame_end
// apb       in   psel/penable/pwrite   frame_width at 0x0, frame_height at 0x4
//
// one pixel transfer per clock while the window stage is empty or retiring; a pixel's
// results pass the window stage and then the output register, which moves one result
// per cycle while out_res is ready, so on the last row (two results per pixel after the
// first column, three on the final one) the input waits until a pixel's results are out
// reset: counters at row 0 column 0, geometry 640 x 480; line memories are not cleared
// a register write restarts the frame; output stalls back up through the window stage
`timescale 1ns / 1ps
module image_central_difference_gradient_unit #(
  parameter int MAX_WIDTH  = cdg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cdg_pkg::DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = cdg_pkg::DEF_PIXEL_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  cdg_pix_if.sink                        in_pix,
  cdg_res_if.source                      out_res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cdg_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [cdg_pkg::APB_DATA_W-1:0] pwdata,
  output logic [cdg_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0]         w_last;
  logic [RW-1:0]         h_last;
  logic                  restart, retire, s_valid;
  cdg_pkg::cdg_ctrl_t    s_ctrl;
  logic [PIXEL_BITS-1:0] s_pix, s_mid_c, s_mid_r, s_up, s_mid_l, s_last, s_second;
  logic [RW-1:0]         s_row;
  logic [CW-1:0]         s_col;

  cdg_cfg_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .w_last  (w_last),
    .h_last  (h_last),
    .restart (restart)
  );

  cdg_line_buf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_line (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (in_pix),
    .w_last   (w_last),
    .h_last   (h_last),
    .restart  (restart),
    .retire   (retire),
    .s_valid  (s_valid),
    .s_ctrl   (s_ctrl),
    .s_pix    (s_pix),
    .s_mid_c  (s_mid_c),
    .s_mid_r  (s_mid_r),
    .s_up     (s_up),
    .s_mid_l  (s_mid_l),
    .s_last   (s_last),
    .s_second (s_second),
    .s_row    (s_row),
    .s_col    (s_col)
  );

  cdg_result_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_valid  (s_valid),
    .s_ctrl   (s_ctrl),
    .s_pix    (s_pix),
    .s_mid_c  (s_mid_c),
    .s_mid_r  (s_mid_r),
    .s_up     (s_up),
    .s_mid_l  (s_mid_l),
    .s_last   (s_last),
    .s_second (s_second),
    .s_row    (s_row),
    .s_col    (s_col),
    .retire   (retire),
    .out_res  (out_res)
  );

endmodule
